FILE: src/cpc_pkg.sv
// shared types, constants and the crc-8 byte step for the controller pack command block
// no dependencies; imported by every module of the block
package cpc_pkg;

    localparam int PACK_BYTES_DEF = 32768;
    localparam int CHANNELS_DEF   = 4;

    localparam int S_TDATA_W = 280;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 288;
    localparam int M_TUSER_W = 2;

    localparam int BLOCK_BYTES = 32;
    localparam int BLOCK_WORDS = 4;
    localparam int CRC_STEPS   = 33;

    localparam logic [1:0] REQ_STATUS   = 2'd0;
    localparam logic [1:0] REQ_PRESENCE = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;
    localparam logic [1:0] REQ_WRITE    = 2'd3;

    localparam logic CFG_DEVICE_MASK = 1'b0;
    localparam logic CFG_PACK_MASK   = 1'b1;

    localparam logic [3:0]  DEVICE_MASK_RST = 4'h1;
    localparam logic [3:0]  PACK_MASK_RST   = 4'h0;
    localparam logic [15:0] DEVICE_TYPE     = 16'h0500;
    localparam logic [15:0] SPECIAL_ADDR    = 16'h8001;
    localparam logic [15:0] ADDR_ALIGN_MASK = 16'hFFE0;
    localparam logic [7:0]  CRC_POLY        = 8'h85;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD,
        ST_RD_WAIT,
        ST_WR,
        ST_CRC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic zero_data;
        logic mem_rd;
        logic mem_wr;
        logic cnt_clr;
        logic cnt_inc;
        logic crc_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       word_last;
        logic       byte_last;
        logic       present;
        logic       mem_ok;
        logic       out_busy;
        logic [1:0] req_type;
    } dp_status_t;

    // msb-first shift of one byte through the crc register
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] c;
        logic [7:0] tap;
        c = crc;
        for (int b = 7; b >= 0; b--)
        begin
            tap = c[7] ? CRC_POLY : 8'h00;
            c   = {c[6:0], din[b]} ^ tap;
        end
        return c;
    endfunction

endpackage

FILE: src/cpc_ctrl.sv
// command sequencer: clearing pass, decode, pack word access and crc steps
// depends on cpc_pkg for the state type and the command and status structs
module cpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cpc_pkg::dp_status_t status,
    output cpc_pkg::ctrl_cmd_t  cmd
);
    import cpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (status.req_type == REQ_STATUS || status.req_type == REQ_PRESENCE
                    || !status.present)
                    state_next = ST_DONE;
                else if (!status.mem_ok)
                    state_next = ST_CRC;
                else if (status.req_type == REQ_READ)
                    state_next = ST_RD;
                else
                    state_next = ST_WR;
            end
            ST_RD:
            begin
                if (status.word_last)
                    state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
                state_next = ST_CRC;
            ST_WR:
            begin
                if (status.word_last)
                    state_next = ST_CRC;
            end
            ST_CRC:
            begin
                if (status.byte_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                cmd.cnt_clr = 1'b1;
            end
            ST_DECODE:
            begin
                cmd.zero_data = (status.req_type == REQ_READ);
                cmd.cnt_clr   = 1'b1;
            end
            ST_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_RD_WAIT:
                cmd.cnt_clr = 1'b1;
            ST_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.cnt_inc = !status.word_last;
                cmd.cnt_clr = status.word_last;
            end
            ST_CRC:
            begin
                cmd.crc_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_DONE:
                cmd.out_load = !status.out_busy;
            default:
                cmd = '0;
        endcase
    end

endmodule

FILE: src/cpc_dpath.sv
// datapath: config masks, request registers, pack store, data block, crc and result register
// depends on cpc_pkg for constants, structs and the crc byte step
module cpc_dpath #(
    parameter int PACK_BYTES = cpc_pkg::PACK_BYTES_DEF,
    parameter int CHANNELS   = cpc_pkg::CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [3:0]         cfg_wdata,
    input  logic [1:0]         req_type,
    input  logic [1:0]         channel,
    input  logic               error_preset,
    input  logic [15:0]        pack_address,
    input  logic [255:0]       wdata_blk,
    input  cpc_pkg::ctrl_cmd_t  cmd,
    output cpc_pkg::dp_status_t status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               no_device,
    output logic               status_valid,
    output logic [15:0]        device_type,
    output logic               pack_flag,
    output logic [255:0]       rdata_blk,
    output logic [7:0]         data_crc,
    output logic               crc_valid
);
    import cpc_pkg::*;

    localparam int WORDS_PER_PACK = PACK_BYTES / 8;
    localparam int MEM_DEPTH      = CHANNELS * WORDS_PER_PACK;
    localparam int ADDR_W         = $clog2(MEM_DEPTH);
    localparam int CNT_W          = (ADDR_W > 6) ? ADDR_W : 6;

    logic [3:0]        dev_mask_reg;
    logic [3:0]        pack_mask_reg;
    logic [1:0]        req_reg;
    logic [1:0]        ch_reg;
    logic              err_reg;
    logic [15:0]       addr_reg;
    logic [255:0]      data_reg;
    logic [7:0]        crc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rd_pend_reg;
    logic [63:0]       mem_q;
    logic [63:0]       mem [0:MEM_DEPTH-1];

    logic              out_valid_reg;
    logic              nodev_out_reg;
    logic              statv_out_reg;
    logic [15:0]       dtype_out_reg;
    logic              pflag_out_reg;
    logic [255:0]      rdata_out_reg;
    logic [7:0]        crc_out_reg;
    logic              crcv_out_reg;

    logic              present;
    logic              pack;
    logic              in_range;
    logic [15:0]       masked;
    logic [31:0]       word_sum;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [63:0]       mem_wdata;
    logic [7:0]        crc_din;

    logic              res_nodev;
    logic              res_statv;
    logic [15:0]       res_dtype;
    logic              res_pflag;
    logic [255:0]      res_rdata;
    logic [7:0]        res_crc;
    logic              res_crcv;

    assign present  = ({1'b0, ch_reg} < 3'(CHANNELS)) && dev_mask_reg[ch_reg];
    assign pack     = present && pack_mask_reg[ch_reg];
    assign masked   = addr_reg & ADDR_ALIGN_MASK;
    assign in_range = (addr_reg != SPECIAL_ADDR)
                      && (({1'b0, masked} + 17'(BLOCK_BYTES)) <= 17'(PACK_BYTES));

    // channel base plus word within the aligned block
    assign word_sum = 32'(ch_reg) * 32'(WORDS_PER_PACK)
                      + 32'({addr_reg[15:5], cnt_reg[1:0]});
    assign mem_addr = cmd.clear_en ? cnt_reg[ADDR_W-1:0] : ADDR_W'(word_sum);
    assign mem_we   = cmd.clear_en || cmd.mem_wr;
    assign mem_wdata = cmd.clear_en ? 64'd0 : data_reg[255:192];

    // the augmenting byte after the 32 data bytes is zero
    assign crc_din = cnt_reg[5] ? 8'h00 : data_reg[255:248];

    assign status.clear_last = (cnt_reg == CNT_W'(MEM_DEPTH - 1));
    assign status.word_last  = (cnt_reg == CNT_W'(BLOCK_WORDS - 1));
    assign status.byte_last  = (cnt_reg == CNT_W'(CRC_STEPS - 1));
    assign status.present    = present;
    assign status.mem_ok     = pack && in_range;
    assign status.out_busy   = out_valid_reg && !m_tready;
    assign status.req_type   = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_mask_reg  <= DEVICE_MASK_RST;
            pack_mask_reg <= PACK_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEVICE_MASK: dev_mask_reg  <= cfg_wdata;
                CFG_PACK_MASK:   pack_mask_reg <= cfg_wdata;
                default:         dev_mask_reg  <= dev_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CNT_W'(1);
            rd_pend_reg <= cmd.mem_rd;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.mem_rd)
            mem_q <= mem[mem_addr];
    end

    // data block: word 0 on top; reads shift in at the bottom, writes and crc rotate
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            ch_reg   <= channel;
            err_reg  <= error_preset;
            addr_reg <= pack_address;
            data_reg <= wdata_blk;
            crc_reg  <= 8'h00;
        end
        else if (cmd.zero_data)
            data_reg <= '0;
        else if (rd_pend_reg)
            data_reg <= {data_reg[191:0], mem_q};
        else if (cmd.mem_wr)
            data_reg <= {data_reg[191:0], data_reg[255:192]};
        else if (cmd.crc_step)
        begin
            crc_reg <= crc8_byte(crc_reg, crc_din);
            if (!cnt_reg[5])
                data_reg <= {data_reg[247:0], data_reg[255:248]};
        end
    end

    always_comb
    begin
        res_nodev = 1'b0;
        res_statv = 1'b0;
        res_dtype = 16'h0000;
        res_pflag = 1'b0;
        res_rdata = '0;
        res_crc   = 8'h00;
        res_crcv  = 1'b0;
        case (req_reg)
            REQ_STATUS:
            begin
                if (!err_reg)
                begin
                    if (present)
                    begin
                        res_statv = 1'b1;
                        res_dtype = DEVICE_TYPE;
                        res_pflag = pack;
                    end
                    else
                        res_nodev = 1'b1;
                end
            end
            REQ_PRESENCE:
                res_nodev = !present;
            default:
            begin
                if (!present)
                    res_nodev = 1'b1;
                else
                begin
                    res_rdata = data_reg;
                    res_crc   = crc_reg;
                    res_crcv  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            nodev_out_reg <= res_nodev;
            statv_out_reg <= res_statv;
            dtype_out_reg <= res_dtype;
            pflag_out_reg <= res_pflag;
            rdata_out_reg <= res_rdata;
            crc_out_reg   <= res_crc;
            crcv_out_reg  <= res_crcv;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign no_device    = nodev_out_reg;
    assign status_valid = statv_out_reg;
    assign device_type  = dtype_out_reg;
    assign pack_flag    = pflag_out_reg;
    assign rdata_blk    = rdata_out_reg;
    assign data_crc     = crc_out_reg;
    assign crc_valid    = crcv_out_reg;

endmodule

FILE: src/controller_pack_command_core.sv
// accept to result: status, presence and absent-device requests go from decode to done;
// pack reads and writes add the 4 store words and 33 crc steps, the crc steps alone when
// the store is skipped; one request at a time, the next taken the cycle after the result
// is registered, later while an earlier result still waits in the output register
// on reset all control state clears at once, then a clearing pass zeroes all CHANNELS *
// PACK_BYTES / 8 store words (16384 by default); depends on cpc_pkg, cpc_ctrl and cpc_dpath
module controller_pack_command_core #(
    parameter int PACK_BYTES = cpc_pkg::PACK_BYTES_DEF,
    parameter int CHANNELS   = cpc_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [3:0]                    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // error_preset, pack_address, wdata0, wdata1, wdata2, wdata3, zero fill
    input  logic [cpc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type, channel
    input  logic [cpc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // no_device, device_type, pack_flag, rdata0, rdata1, rdata2, rdata3, data_crc, zero fill
    output logic [cpc_pkg::M_TDATA_W-1:0] m_tdata,
    // status_valid, crc_valid
    output logic [cpc_pkg::M_TUSER_W-1:0] m_tuser
);
    import cpc_pkg::*;

    ctrl_cmd_t    cmd;
    dp_status_t   status;
    logic [255:0] wdata_blk;
    logic [255:0] rdata_blk;
    logic         no_device;
    logic         status_valid;
    logic [15:0]  device_type;
    logic         pack_flag;
    logic [7:0]   data_crc;
    logic         crc_valid;

    assign wdata_blk = {s_tdata[80:17], s_tdata[144:81], s_tdata[208:145], s_tdata[272:209]};

    cpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpc_dpath #(
        .PACK_BYTES (PACK_BYTES),
        .CHANNELS   (CHANNELS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .req_type     (s_tuser[1:0]),
        .channel      (s_tuser[3:2]),
        .error_preset (s_tdata[0]),
        .pack_address (s_tdata[16:1]),
        .wdata_blk    (wdata_blk),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .no_device    (no_device),
        .status_valid (status_valid),
        .device_type  (device_type),
        .pack_flag    (pack_flag),
        .rdata_blk    (rdata_blk),
        .data_crc     (data_crc),
        .crc_valid    (crc_valid)
    );

    assign m_tdata = {6'd0, data_crc, rdata_blk[63:0], rdata_blk[127:64], rdata_blk[191:128],
                      rdata_blk[255:192], pack_flag, device_type, no_device};
    assign m_tuser = {crc_valid, status_valid};

endmodule

FILE: src/cpc_checker.sv
// port-level checks on the controller pack command block, bound to the top level
// depends on cpc_pkg and controller_pack_command_core
module cpc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cpc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cpc_pkg::M_TUSER_W-1:0] m_tuser
);
    import cpc_pkg::*;

    // a result held back stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: no request straight after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // data results never come with the absent-device error or the status flag
    a_crc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tdata[0] && !m_tuser[0])
        else $error("crc result flagged with no device or status");

    // status results report the fixed device type and no error
    a_status_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[16:1] == DEVICE_TYPE && !m_tdata[0])
        else $error("status result with wrong device type");

endmodule

bind controller_pack_command_core cpc_checker u_checker (.*);
